### design/citr_pkg.sv
`default_nettype none
package citr_pkg;

    localparam int MAX_IDS = 64;
    localparam int IDX_W   = $clog2(MAX_IDS);
    localparam int CNT_W   = $clog2(MAX_IDS + 1);

    localparam int OP_W       = 2;
    localparam int ID_W       = 29;
    localparam int DATA_W     = 64;
    localparam int PLEN_W     = 8;
    localparam int LEN_W      = 4;
    localparam int TIME_W     = 32;
    localparam int IDXIN_W    = 6;
    localparam int USED_W     = 7;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 8;
    localparam int CMP_W      = (CNT_W > IDXIN_W) ? CNT_W : IDXIN_W;

    localparam int MAX_BYTES = 8;
    localparam int SCALE_W   = 20;
    localparam logic [SCALE_W-1:0] RATE_SCALE = 20'd1000000;
    localparam int DIVD_W    = TIME_W + SCALE_W;

    localparam logic [CFG_W-1:0] STALE_RESET  = 16'd2000;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd1000;

    localparam logic [OP_W-1:0] OP_OBSERVE = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_STALE  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = 8'd1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] seen;
        logic [TIME_W-1:0] total;
        logic [TIME_W-1:0] wstart;
        logic [TIME_W-1:0] wcount;
        logic [TIME_W-1:0] rate;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // keep only the first len bytes
    function automatic logic [DATA_W-1:0] clamp_data(input logic [DATA_W-1:0] d,
                                                     input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] r;
        r = '0;
        for (int b = 0; b < MAX_BYTES; b++) begin
            if (LEN_W'(b) < len) begin
                r[b*8 +: 8] = d[b*8 +: 8];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/can_id_rate_tracker_core.sv
`default_nettype none
// channel   | ports                                   | direction
// ----------+-----------------------------------------+----------
// s_        | s_valid/s_ready, operation and item     | in
// m_        | m_valid/m_ready, a result per known op  | out
// cfg_      | cfg_valid/cfg_ready, cfg_addr/cfg_wdata | in
//
// one transaction at a time: an identifier lookup walks the sorted table, entry by entry
// insert moves every entry above the new position, one at a time
// a rate update adds a multiply state and 52 divider steps; an index read waits for the RAM
// reset clears the fill count, not the table, so the table needs no clearing pass
// a result waiting on m_ready holds the next transaction in its done state
module can_id_rate_tracker_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [citr_pkg::OP_W-1:0]         s_operation,
    input  wire logic [citr_pkg::ID_W-1:0]         s_can_id,
    input  wire logic [citr_pkg::DATA_W-1:0]       s_payload,
    input  wire logic [citr_pkg::PLEN_W-1:0]       s_payload_length,
    input  wire logic [citr_pkg::TIME_W-1:0]       s_now_ms,
    input  wire logic [citr_pkg::IDXIN_W-1:0]      s_entry_index,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_found,
    output logic                                   m_dropped,
    output logic      [citr_pkg::ID_W-1:0]         m_entry_id,
    output logic      [citr_pkg::DATA_W-1:0]       m_last_payload,
    output logic      [citr_pkg::LEN_W-1:0]        m_last_length,
    output logic      [citr_pkg::TIME_W-1:0]       m_last_seen,
    output logic      [citr_pkg::TIME_W-1:0]       m_total_frames,
    output logic      [citr_pkg::TIME_W-1:0]       m_frequency_milli_hz,
    output logic      [citr_pkg::USED_W-1:0]       m_entries_used,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [citr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [citr_pkg::CFG_W-1:0]        cfg_wdata
);
    import citr_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_RD_WAIT  = 11'b000_0000_0010,
        ST_SRCH_RD  = 11'b000_0000_0100,
        ST_SRCH_CMP = 11'b000_0000_1000,
        ST_SHIFT_RD = 11'b000_0001_0000,
        ST_SHIFT_WR = 11'b000_0010_0000,
        ST_UPDATE   = 11'b000_0100_0000,
        ST_MUL      = 11'b000_1000_0000,
        ST_DIV      = 11'b001_0000_0000,
        ST_WRITE    = 11'b010_0000_0000,
        ST_DONE     = 11'b100_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   sh_reg, sh_next;
    logic [CFG_W-1:0]   stale_reg, window_reg;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [DATA_W-1:0]  payload_reg, payload_next;
    logic [PLEN_W-1:0]  plen_reg, plen_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    entry_t             ent_reg, ent_next;
    logic [DIVD_W-1:0]  prod_reg, prod_next;
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;
    logic               res_found_reg, res_found_next;
    logic               res_drop_reg, res_drop_next;
    logic [TIME_W-1:0]  res_freq_reg, res_freq_next;
    logic               m_valid_reg, m_valid_next;
    logic               load_out;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    entry_t             ram_wdata, ram_rdata;
    logic               div_start, div_done;
    logic [DIVD_W-1:0]  div_q;

    logic [CMP_W-1:0]   idx_ext;
    logic [CNT_W-1:0]   sh_dec;
    entry_t             upd;
    logic [TIME_W-1:0]  age;
    logic [TIME_W-1:0]  elapsed;
    logic [CFG_W-1:0]   win;
    logic [LEN_W-1:0]   len_c;
    logic               at_miss;

    assign idx_ext   = CMP_W'(s_entry_index);
    assign sh_dec    = sh_reg - 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign len_c     = (plen_reg > PLEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : plen_reg[LEN_W-1:0];

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        sh_next        = sh_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        payload_next   = payload_reg;
        plen_next      = plen_reg;
        now_next       = now_reg;
        ent_next       = ent_reg;
        prod_next      = prod_reg;
        elapsed_next   = elapsed_reg;
        res_found_next = res_found_reg;
        res_drop_next  = res_drop_reg;
        res_freq_next  = res_freq_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        load_out       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg[IDX_W-1:0];
        ram_wdata      = ent_reg;
        ram_raddr      = ptr_reg[IDX_W-1:0];
        div_start      = 1'b0;
        at_miss        = 1'b0;
        upd            = ent_reg;
        age            = now_reg - ram_rdata.seen;
        elapsed        = now_reg - ent_reg.wstart;
        win            = (window_reg == '0) ? CFG_W'(1) : window_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next      = s_operation;
                    id_next      = s_can_id;
                    payload_next = s_payload;
                    plen_next    = s_payload_length;
                    now_next     = s_now_ms;
                    ptr_next     = '0;
                    if (s_operation == OP_OBSERVE || s_operation == OP_QUERY) begin
                        state_next = ST_SRCH_RD;
                    end else if (s_operation == OP_READ) begin
                        if (idx_ext < CMP_W'(count_reg)) begin
                            ram_raddr  = idx_ext[IDX_W-1:0];
                            state_next = ST_RD_WAIT;
                        end else begin
                            res_found_next = 1'b0;
                            res_drop_next  = 1'b0;
                            res_freq_next  = '0;
                            ent_next       = '0;
                            state_next     = ST_DONE;
                        end
                    end
                end
            end
            ST_RD_WAIT: begin
                ent_next       = ram_rdata;
                res_found_next = 1'b1;
                res_drop_next  = 1'b0;
                res_freq_next  = ram_rdata.rate;
                state_next     = ST_DONE;
            end
            ST_SRCH_RD: begin
                if (ptr_reg == count_reg) begin
                    at_miss = 1'b1;
                end else begin
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                if (ram_rdata.id < id_reg) begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end else if (ram_rdata.id == id_reg) begin
                    ent_next = ram_rdata;
                    if (op_reg == OP_QUERY) begin
                        res_found_next = 1'b1;
                        res_drop_next  = 1'b0;
                        res_freq_next  = (ram_rdata.seen == '0 || age > TIME_W'(stale_reg))
                                         ? '0 : ram_rdata.rate;
                        state_next     = ST_DONE;
                    end else begin
                        state_next = ST_UPDATE;
                    end
                end else begin
                    at_miss = 1'b1;
                end
            end
            ST_SHIFT_RD: begin
                if (sh_reg == ptr_reg) begin
                    state_next = ST_UPDATE;
                end else begin
                    ram_raddr  = sh_dec[IDX_W-1:0];
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = sh_reg[IDX_W-1:0];
                ram_wdata  = ram_rdata;
                sh_next    = sh_dec;
                state_next = ST_SHIFT_RD;
            end
            ST_UPDATE: begin
                upd.len   = len_c;
                upd.data  = clamp_data(payload_reg, len_c);
                upd.seen  = now_reg;
                upd.total = ent_reg.total + 1'b1;
                state_next = ST_WRITE;
                if (ent_reg.wstart == '0) begin
                    // window not started yet
                    upd.wstart = now_reg;
                    upd.wcount = '0;
                end else begin
                    upd.wcount = ent_reg.wcount + 1'b1;
                    if (elapsed >= TIME_W'(win)) begin
                        prod_next    = DIVD_W'(upd.wcount) * DIVD_W'(RATE_SCALE);
                        elapsed_next = elapsed;
                        state_next   = ST_MUL;
                    end
                end
                ent_next = upd;
            end
            ST_MUL: begin
                div_start       = 1'b1;
                ent_next.wstart = now_reg;
                ent_next.wcount = '0;
                state_next      = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    ent_next.rate = (|div_q[DIVD_W-1:TIME_W]) ? '1 : div_q[TIME_W-1:0];
                    state_next    = ST_WRITE;
                end
            end
            ST_WRITE: begin
                ram_we         = 1'b1;
                res_found_next = 1'b1;
                res_drop_next  = 1'b0;
                res_freq_next  = ent_reg.rate;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (at_miss) begin
            res_found_next = 1'b0;
            res_drop_next  = 1'b0;
            res_freq_next  = '0;
            ent_next       = '0;
            state_next     = ST_DONE;
            if (op_reg == OP_OBSERVE) begin
                if (count_reg >= CNT_W'(MAX_IDS)) begin
                    res_drop_next = 1'b1;
                end else begin
                    // open a zeroed slot at ptr by moving the tail up
                    ent_next.id = id_reg;
                    sh_next     = count_reg;
                    count_next  = count_reg + 1'b1;
                    state_next  = ST_SHIFT_RD;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            stale_reg   <= STALE_RESET;
            window_reg  <= WINDOW_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_addr == REG_STALE) begin
                    stale_reg <= cfg_wdata;
                end else if (cfg_addr == REG_WINDOW) begin
                    window_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        sh_reg        <= sh_next;
        op_reg        <= op_next;
        id_reg        <= id_next;
        payload_reg   <= payload_next;
        plen_reg      <= plen_next;
        now_reg       <= now_next;
        ent_reg       <= ent_next;
        prod_reg      <= prod_next;
        elapsed_reg   <= elapsed_next;
        res_found_reg <= res_found_next;
        res_drop_reg  <= res_drop_next;
        res_freq_reg  <= res_freq_next;
        if (load_out) begin
            m_found              <= res_found_reg;
            m_dropped            <= res_drop_reg;
            m_entry_id           <= ent_reg.id;
            m_last_payload       <= ent_reg.data;
            m_last_length        <= ent_reg.len;
            m_last_seen          <= ent_reg.seen;
            m_total_frames       <= ent_reg.total;
            m_frequency_milli_hz <= res_freq_reg;
            m_entries_used       <= USED_W'(count_reg);
        end
    end

    assign m_valid = m_valid_reg;

    citr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_IDS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    citr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_IDS))
        else $error("table count beyond capacity");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1))
        else $error("table count moved by more than one");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    a_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> !(m_found && m_dropped))
        else $error("result both found and dropped");

endmodule
`default_nettype wire

### design/citr_ram.sv
`default_nettype none
module citr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### design/citr_div.sv
`default_nettype none
module citr_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [citr_pkg::DIVD_W-1:0]   dividend,
    input  wire logic [citr_pkg::TIME_W-1:0]   divisor,
    output logic                               done,
    output logic      [citr_pkg::DIVD_W-1:0]   quotient
);
    import citr_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] num_reg, num_next;
    logic [TIME_W-1:0] den_reg, den_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TIME_W:0]   rem_sh;
    logic [TIME_W:0]   rem_sub;
    logic              qbit;

    // restoring division, one quotient bit a cycle; quotient shifts in behind the dividend
    always_comb begin
        rem_sh  = {rem_reg, num_reg[DIVD_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        qbit    = (rem_sh >= {1'b0, den_reg});
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next  = {num_reg[DIVD_W-2:0], qbit};
            rem_next  = qbit ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule
`default_nettype wire

### sim/tb_can_id_rate_tracker_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_can_id_rate_tracker_core;
    import citr_pkg::*;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [ID_W-1:0]    id;
        logic [DATA_W-1:0]  payload;
        logic [PLEN_W-1:0]  plen;
        logic [TIME_W-1:0]  now;
        logic [IDXIN_W-1:0] idx;
    } frame_t;

    typedef struct {
        logic               found;
        logic               dropped;
        logic [ID_W-1:0]    id;
        logic [DATA_W-1:0]  data;
        logic [LEN_W-1:0]   len;
        logic [TIME_W-1:0]  seen;
        logic [TIME_W-1:0]  total;
        logic [TIME_W-1:0]  freq;
        logic [USED_W-1:0]  used;
    } answer_t;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_UNKNOWN = 8'd7;
    localparam int SETTLE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    // mirror of the identifier table and its registers
    class id_table_model;
        logic [ID_W-1:0]   ids     [MAX_IDS];
        logic [DATA_W-1:0] data    [MAX_IDS];
        logic [LEN_W-1:0]  lens    [MAX_IDS];
        logic [TIME_W-1:0] seen    [MAX_IDS];
        logic [TIME_W-1:0] total   [MAX_IDS];
        logic [TIME_W-1:0] wstart  [MAX_IDS];
        logic [TIME_W-1:0] wcount  [MAX_IDS];
        logic [TIME_W-1:0] rate    [MAX_IDS];
        int                used;
        logic [CFG_W-1:0]  stale_ms;
        logic [CFG_W-1:0]  window_ms;
        answer_t           expected_answers[$];
        int                errors;
        int                checked;
        int                drops;
        int                rate_updates;

        function new();
            used = 0;
            stale_ms = STALE_RESET;
            window_ms = WINDOW_RESET;
            errors = 0;
            checked = 0;
            drops = 0;
            rate_updates = 0;
            for (int i = 0; i < MAX_IDS; i++) begin
                ids[i] = '0; data[i] = '0; lens[i] = '0; seen[i] = '0;
                total[i] = '0; wstart[i] = '0; wcount[i] = '0; rate[i] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] v);
            if (addr == REG_STALE) stale_ms = v;
            else if (addr == REG_WINDOW) window_ms = v;
        endfunction

        function answer_t miss();
            answer_t a;
            a = '{default: '0};
            a.used = USED_W'(used);
            return a;
        endfunction

        function answer_t slot_answer(int p, logic [TIME_W-1:0] f);
            answer_t a;
            a.found = 1'b1; a.dropped = 1'b0;
            a.id = ids[p]; a.data = data[p]; a.len = lens[p]; a.seen = seen[p];
            a.total = total[p]; a.freq = f; a.used = USED_W'(used);
            return a;
        endfunction

        function void note_transaction(frame_t t);
            int p;
            bit hit;
            answer_t a;
            int n;
            logic [TIME_W-1:0] elapsed;
            logic [TIME_W-1:0] win;
            logic [63:0] q;
            p = 0;
            while (p < used && ids[p] < t.id) p++;
            hit = (p < used) && (ids[p] == t.id);
            case (t.op)
                OP_OBSERVE: begin
                    if (!hit && used >= MAX_IDS) begin
                        a = miss();
                        a.dropped = 1'b1;
                        drops++;
                        expected_answers.push_back(a);
                        return;
                    end
                    if (!hit) begin
                        for (int k = used; k > p; k--) begin
                            ids[k] = ids[k-1]; data[k] = data[k-1]; lens[k] = lens[k-1];
                            seen[k] = seen[k-1]; total[k] = total[k-1];
                            wstart[k] = wstart[k-1]; wcount[k] = wcount[k-1];
                            rate[k] = rate[k-1];
                        end
                        ids[p] = t.id; data[p] = '0; lens[p] = '0; seen[p] = '0;
                        total[p] = '0; wstart[p] = '0; wcount[p] = '0; rate[p] = '0;
                        used++;
                    end
                    n = (t.plen > 8) ? 8 : int'(t.plen);
                    lens[p] = LEN_W'(n);
                    data[p] = (n == 8) ? t.payload : (t.payload & ((64'd1 << (n * 8)) - 1));
                    seen[p] = t.now;
                    total[p] = total[p] + 1;
                    if (wstart[p] == 0) begin
                        wstart[p] = t.now;
                        wcount[p] = '0;
                    end else begin
                        wcount[p] = wcount[p] + 1;
                        elapsed = t.now - wstart[p];
                        win = (window_ms == 0) ? 1 : TIME_W'(window_ms);
                        if (elapsed >= win) begin
                            q = (64'(wcount[p]) * 64'd1000000) / 64'(elapsed);
                            rate[p] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                            wstart[p] = t.now;
                            wcount[p] = '0;
                            rate_updates++;
                        end
                    end
                    expected_answers.push_back(slot_answer(p, rate[p]));
                end
                OP_QUERY: begin
                    if (!hit) expected_answers.push_back(miss());
                    else if (seen[p] == 0 || (t.now - seen[p]) > TIME_W'(stale_ms))
                        expected_answers.push_back(slot_answer(p, '0));
                    else expected_answers.push_back(slot_answer(p, rate[p]));
                end
                OP_READ: begin
                    if (int'(t.idx) >= used) expected_answers.push_back(miss());
                    else expected_answers.push_back(slot_answer(int'(t.idx), rate[t.idx]));
                end
                default: ;
            endcase
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        endtask

        task check_result(answer_t got);
            answer_t w;
            if (expected_answers.size() == 0) begin
                report("unexpected result", 64'(got.id), 0);
                return;
            end
            w = expected_answers.pop_front();
            checked++;
            if (got.found !== w.found) report("found", 64'(got.found), 64'(w.found));
            if (got.dropped !== w.dropped) report("dropped", 64'(got.dropped), 64'(w.dropped));
            if (got.id !== w.id) report("entry_id", 64'(got.id), 64'(w.id));
            if (got.data !== w.data) report("last_payload", got.data, w.data);
            if (got.len !== w.len) report("last_length", 64'(got.len), 64'(w.len));
            if (got.seen !== w.seen) report("last_seen", 64'(got.seen), 64'(w.seen));
            if (got.total !== w.total) report("total_frames", 64'(got.total), 64'(w.total));
            if (got.freq !== w.freq) report("frequency", 64'(got.freq), 64'(w.freq));
            if (got.used !== w.used) report("entries_used", 64'(got.used), 64'(w.used));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [OP_W-1:0]       s_operation;
    logic [ID_W-1:0]       s_can_id;
    logic [DATA_W-1:0]     s_payload;
    logic [PLEN_W-1:0]     s_payload_length;
    logic [TIME_W-1:0]     s_now_ms;
    logic [IDXIN_W-1:0]    s_entry_index;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_found;
    logic                  m_dropped;
    logic [ID_W-1:0]       m_entry_id;
    logic [DATA_W-1:0]     m_last_payload;
    logic [LEN_W-1:0]      m_last_length;
    logic [TIME_W-1:0]     m_last_seen;
    logic [TIME_W-1:0]     m_total_frames;
    logic [TIME_W-1:0]     m_frequency_milli_hz;
    logic [USED_W-1:0]     m_entries_used;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    can_id_rate_tracker_core u_top (.*);

    id_table_model table_model = new();
    logic [ID_W-1:0] id_pool [100];
    logic [TIME_W-1:0] clock_ms;
    int  hold_request;
    int  idle_cycles;
    int  sent;

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // receiver: alternating stall patterns, plus a long hold on request
    initial begin
        int hold_left;
        int cyc;
        hold_left = 0;
        cyc = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else if ((cyc / 300) % 3 == 0) begin
                m_ready = 1'b1;
            end else if ((cyc / 300) % 3 == 1) begin
                m_ready = ($urandom_range(0, 3) != 0);
            end else begin
                m_ready = ($urandom_range(0, 9) < 3);
            end
        end
    end

    always @(posedge aclk) begin
        answer_t got;
        if (aresetn && m_valid && m_ready) begin
            got.found = m_found; got.dropped = m_dropped; got.id = m_entry_id;
            got.data = m_last_payload; got.len = m_last_length; got.seen = m_last_seen;
            got.total = m_total_frames; got.freq = m_frequency_milli_hz;
            got.used = m_entries_used;
            table_model.check_result(got);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout with %0d results outstanding",
                         table_model.expected_answers.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task send_frame(frame_t t);
        @(negedge aclk);
        s_valid = 1'b1;
        s_operation = t.op; s_can_id = t.id; s_payload = t.payload;
        s_payload_length = t.plen; s_now_ms = t.now; s_entry_index = t.idx;
        do @(posedge aclk); while (!s_ready);
        table_model.note_transaction(t);
        sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task drain_and_settle();
        while (table_model.expected_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] v);
        @(negedge aclk);
        cfg_valid = 1'b1; cfg_addr = addr; cfg_wdata = v;
        do @(posedge aclk); while (!cfg_ready);
        table_model.write_reg(addr, v);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task set_timing(logic [CFG_W-1:0] stale, logic [CFG_W-1:0] window);
        drain_and_settle();
        write_register(REG_STALE, stale);
        write_register(REG_WINDOW, window);
        write_register(REG_UNKNOWN, CFG_W'($urandom));
    endtask

    function frame_t make_frame(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                logic [DATA_W-1:0] pl, logic [PLEN_W-1:0] len,
                                logic [TIME_W-1:0] now, logic [IDXIN_W-1:0] idx);
        frame_t t;
        t.op = op; t.id = id; t.payload = pl; t.plen = len; t.now = now; t.idx = idx;
        return t;
    endfunction

    function frame_t random_frame(int pool_size);
        frame_t t;
        int r;
        r = $urandom_range(0, 99);
        if (r < 1) clock_ms = $urandom;
        else if (r < 3) clock_ms = '0;
        else clock_ms = clock_ms + $urandom_range(0, 400);
        r = $urandom_range(0, 99);
        t.op = (r < 55) ? OP_OBSERVE : (r < 75) ? OP_QUERY : (r < 96) ? OP_READ : OP_UNUSED;
        t.id = ($urandom_range(0, 19) == 0) ? ID_W'($urandom)
                                            : id_pool[$urandom_range(0, pool_size - 1)];
        t.payload = {$urandom, $urandom};
        t.plen = ($urandom_range(0, 4) == 0) ? PLEN_W'($urandom) : PLEN_W'($urandom_range(0, 8));
        t.now = clock_ms;
        t.idx = IDXIN_W'($urandom);
        return t;
    endfunction

    task random_phase(int count, int pool_size);
        int burst;
        for (int n = 0; n < count; ) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && n < count; b++, n++) send_frame(random_frame(pool_size));
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0; s_operation = OP_OBSERVE; s_can_id = '0; s_payload = '0;
        s_payload_length = '0; s_now_ms = '0; s_entry_index = '0;
        cfg_valid = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        hold_request = 0;
        idle_cycles = 0;
        sent = 0;
        clock_ms = 32'd5000;
        id_pool[0] = '0;
        id_pool[1] = {ID_W{1'b1}};
        for (int i = 2; i < 100; i++) id_pool[i] = ID_W'($urandom);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: sentinel time, extremes, stale, misses, wrap, unused operation
        send_frame(make_frame(OP_READ, '0, '0, '0, '0, '0));
        send_frame(make_frame(OP_QUERY, '0, '0, '0, 32'd10, '0));
        send_frame(make_frame(OP_OBSERVE, '0, '1, 8'd3, '0, '0));
        send_frame(make_frame(OP_OBSERVE, '0, '1, 8'd255, 32'd100, '0));
        send_frame(make_frame(OP_OBSERVE, '0, 64'h0123_4567_89ab_cdef, 8'd5, 32'd600, '0));
        send_frame(make_frame(OP_OBSERVE, '0, '1, 8'd8, 32'd1100, '0));
        send_frame(make_frame(OP_OBSERVE, {ID_W{1'b1}}, '1, 8'd0, 32'hFFFF_FFF0, '0));
        send_frame(make_frame(OP_OBSERVE, {ID_W{1'b1}}, '1, 8'd9, 32'h0000_0400, '0));
        send_frame(make_frame(OP_OBSERVE, {ID_W{1'b1}}, '1, 8'd1, 32'h0000_0800, '0));
        send_frame(make_frame(OP_OBSERVE, 29'h0AA_5555, {32'h5555_5555, 32'hAAAA_AAAA},
                              8'd7, 32'd1200, '0));
        send_frame(make_frame(OP_QUERY, '0, '0, '0, 32'd1500, '0));
        send_frame(make_frame(OP_QUERY, '0, '0, '0, 32'd9000, '0));
        send_frame(make_frame(OP_QUERY, 29'h0AA_5555, '0, '0, 32'd1200, '0));
        send_frame(make_frame(OP_QUERY, 29'h123, '0, '0, 32'd1200, '0));
        send_frame(make_frame(OP_READ, '0, '0, '0, '0, 6'd0));
        send_frame(make_frame(OP_READ, '0, '0, '0, '0, 6'd2));
        send_frame(make_frame(OP_READ, '0, '0, '0, '0, 6'd3));
        send_frame(make_frame(OP_READ, '0, '0, '0, '0, 6'd63));
        send_frame(make_frame(OP_UNUSED, '1, '1, '1, '1, '1));
        send_frame(make_frame(OP_QUERY, {ID_W{1'b1}}, '0, '0, 32'h0000_0900, '0));

        random_phase(300, 30);
        set_timing(16'd0, 16'd0);
        random_phase(300, 40);
        // long receiver hold while the sender keeps offering
        hold_request = 600;
        random_phase(100, 40);
        // sender pauses until the table has answered everything
        while (table_model.expected_answers.size() != 0) @(posedge aclk);
        set_timing(16'hFFFF, 16'hFFFF);
        random_phase(300, 70);
        set_timing(CFG_W'($urandom), CFG_W'($urandom_range(1, 300)));
        random_phase(350, 100);
        set_timing(16'd300, 16'd1);
        random_phase(350, 100);

        drain_and_settle();
        $display("%0d transactions sent, %0d results checked, %0d dropped, %0d rate updates",
                 sent, table_model.checked, table_model.drops, table_model.rate_updates);
        $display("table reached %0d entries across five register settings",
                 table_model.used);
        if (table_model.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
design/citr_pkg.sv
design/citr_ram.sv
design/citr_div.sv
design/can_id_rate_tracker_core.sv
sim/tb_can_id_rate_tracker_core.sv
